/* rtl/cave_pkg.sv */
// ----------------------------------------------------------------------------
// cave_pkg
// Shared types and constants for the cave generation cellular automaton.
// ----------------------------------------------------------------------------
package cave_pkg;

    localparam int CAVE_MAX_SIDE = 64;

    localparam int OPCODE_W = 2;
    localparam int COORD_W  = 6;
    localparam int LIMIT_W  = 3;
    localparam int SIDE_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [OPCODE_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_STEP   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BIRTH_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEATH_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS   = 2'd3;

    localparam logic [LIMIT_W-1:0] BIRTH_LIMIT_RST = 3'd4;
    localparam logic [LIMIT_W-1:0] DEATH_LIMIT_RST = 3'd3;
    localparam logic [SIDE_W-1:0]  GRID_SIDE_RST   = 7'd64;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_PRIME,
        ST_CALC
    } state_t;

endpackage

/* rtl/cave_cellular_automaton.sv */
// ----------------------------------------------------------------------------
// cave_cellular_automaton
// Binary cave grid in a row-wide memory; cell write, cell read and one
// generation step with birth and death limits, edges counting as live.
// ----------------------------------------------------------------------------
// Throughput: in_ready is high only in idle, so a write or read completes
// before the next item is taken; a step sweeps one grid row per cycle
// through the simple dual-port row memory.
// Reset: a clearing pass writes zero to every row, with in_ready low;
// config registers return to their defaults at once.
module cave_cellular_automaton #(
    parameter int MAX_SIDE = cave_pkg::CAVE_MAX_SIDE
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [cave_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cave_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [cave_pkg::OPCODE_W-1:0]    opcode,
    input  logic [cave_pkg::COORD_W-1:0]     row,
    input  logic [cave_pkg::COORD_W-1:0]     col,
    input  logic                             cell_in,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             cell_out
);
    import cave_pkg::*;

    localparam int RA_W = $clog2(MAX_SIDE);
    localparam int SZ_W = $clog2(MAX_SIDE + 1);

    logic [MAX_SIDE-1:0] mem [MAX_SIDE];
    logic [MAX_SIDE-1:0] rd_data_reg;
    logic [RA_W-1:0]     rd_addr;
    logic                wr_en;
    logic [RA_W-1:0]     wr_addr;
    logic [MAX_SIDE-1:0] wr_data;

    state_t state_reg, state_next;
    logic [SZ_W-1:0]     r_reg, r_next;
    logic [MAX_SIDE-1:0] prev_reg, prev_next;
    logic [MAX_SIDE-1:0] cur_reg, cur_next;
    logic [RA_W-1:0]     op_row_reg, op_row_next;
    logic [RA_W-1:0]     op_col_reg, op_col_next;
    logic                op_val_reg, op_val_next;
    logic                inside_reg, inside_next;
    logic                out_valid_reg, out_valid_next;
    logic                cell_out_reg, cell_out_next;

    logic [LIMIT_W-1:0]  birth_reg, death_reg;
    logic [SIDE_W-1:0]   rows_reg, cols_reg;
    logic [SZ_W-1:0]     rows_eff, cols_eff;

    logic                in_inside;
    logic                last_row;
    logic [MAX_SIDE-1:0] col_mask;
    logic [MAX_SIDE-1:0] next_row;
    logic [MAX_SIDE-1:0] new_row;

    // size clamp to 1..MAX_SIDE
    always_comb
    begin
        if (rows_reg == '0)
            rows_eff = SZ_W'(1);
        else if (32'(rows_reg) > 32'(MAX_SIDE))
            rows_eff = SZ_W'(MAX_SIDE);
        else
            rows_eff = SZ_W'(rows_reg);
        if (cols_reg == '0)
            cols_eff = SZ_W'(1);
        else if (32'(cols_reg) > 32'(MAX_SIDE))
            cols_eff = SZ_W'(MAX_SIDE);
        else
            cols_eff = SZ_W'(cols_reg);
    end

    assign in_inside = (32'(row) < 32'(rows_eff)) && (32'(col) < 32'(cols_eff));
    assign last_row  = (32'(r_reg) + 32'd1 >= 32'(rows_eff));

    always_comb
    begin
        for (int c = 0; c < MAX_SIDE; c++)
            col_mask[c] = (c < int'(cols_eff));
    end

    assign next_row = last_row ? {MAX_SIDE{1'b1}} : rd_data_reg;

    // one generation for row r; outside columns read as live
    always_comb
    begin
        logic [MAX_SIDE+1:0] pe, ce, ne;
        logic [3:0]          cnt;
        pe = {1'b1, prev_reg | ~col_mask, 1'b1};
        ce = {1'b1, cur_reg | ~col_mask, 1'b1};
        ne = {1'b1, next_row | ~col_mask, 1'b1};
        new_row = cur_reg;
        for (int c = 0; c < MAX_SIDE; c++)
        begin
            cnt = 4'(pe[c]) + 4'(pe[c+1]) + 4'(pe[c+2]) + 4'(ce[c]) + 4'(ce[c+2])
                + 4'(ne[c]) + 4'(ne[c+1]) + 4'(ne[c+2]);
            if (col_mask[c])
            begin
                if (cur_reg[c])
                    new_row[c] = !(cnt < {1'b0, death_reg});
                else
                    new_row[c] = (cnt > {1'b0, birth_reg});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            birth_reg <= BIRTH_LIMIT_RST;
            death_reg <= DEATH_LIMIT_RST;
            rows_reg  <= GRID_SIDE_RST;
            cols_reg  <= GRID_SIDE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_BIRTH_LIMIT: birth_reg <= cfg_wdata[LIMIT_W-1:0];
                REG_DEATH_LIMIT: death_reg <= cfg_wdata[LIMIT_W-1:0];
                REG_GRID_ROWS:   rows_reg  <= cfg_wdata[SIDE_W-1:0];
                REG_GRID_COLS:   cols_reg  <= cfg_wdata[SIDE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            r_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            r_reg         <= r_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        op_row_reg   <= op_row_next;
        op_col_reg   <= op_col_next;
        op_val_reg   <= op_val_next;
        inside_reg   <= inside_next;
        cell_out_reg <= cell_out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        op_row_next    = op_row_reg;
        op_col_next    = op_col_reg;
        op_val_next    = op_val_reg;
        inside_next    = inside_reg;
        cell_out_next  = cell_out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        rd_addr        = op_row_reg;
        wr_en          = 1'b0;
        wr_addr        = r_reg[RA_W-1:0];
        wr_data        = new_row;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_data = '0;
                r_next  = r_reg + SZ_W'(1);
                if (32'(r_reg) == MAX_SIDE - 1)
                begin
                    r_next     = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                rd_addr  = RA_W'(row);
                if (in_valid)
                begin
                    op_row_next = RA_W'(row);
                    op_col_next = RA_W'(col);
                    op_val_next = cell_in;
                    inside_next = in_inside;
                    case (opcode)
                        OP_WRITE:
                            if (in_inside)
                                state_next = ST_WRITE;
                        OP_STEP:
                        begin
                            rd_addr    = '0;
                            r_next     = '0;
                            prev_next  = {MAX_SIDE{1'b1}};
                            state_next = ST_PRIME;
                        end
                        OP_READ:
                            state_next = ST_READ;
                        default: ;
                    endcase
                end
            end
            ST_WRITE:
            begin
                wr_en               = 1'b1;
                wr_addr             = op_row_reg;
                wr_data             = rd_data_reg;
                wr_data[op_col_reg] = op_val_reg;
                state_next          = ST_IDLE;
            end
            ST_READ:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    cell_out_next  = inside_reg & rd_data_reg[op_col_reg];
                    state_next     = ST_IDLE;
                end
            end
            ST_PRIME:
            begin
                cur_next   = rd_data_reg;
                rd_addr    = RA_W'(1);
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                wr_en     = 1'b1;
                prev_next = cur_reg;
                cur_next  = rd_data_reg;
                r_next    = r_reg + SZ_W'(1);
                rd_addr   = RA_W'(32'(r_reg) + 32'd2);
                if (last_row)
                begin
                    r_next     = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign cell_out  = cell_out_reg;

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !in_ready)
        else $error("item accepted during clearing pass");

    a_calc_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC) |-> (32'(r_reg) < 32'(rows_eff)))
        else $error("step row beyond active region");

    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_READ))
        else $error("result beat without a read");

endmodule

/* tb/tb_cave_cellular_automaton.sv */
// ----------------------------------------------------------------------------
// tb_cave_cellular_automaton
// Self-checking bench for the cave automaton: a directed table, then random
// phases of cell writes, reads and generation steps over several register
// settings. A bit-level grid predictor checks every read beat; both sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb_cave_cellular_automaton;
    import cave_pkg::*;

    localparam int SIDE        = CAVE_MAX_SIDE;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE      = 2 * SIDE + 20;
    localparam int PHASE_ITEMS = 250;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_ready;
    logic [OPCODE_W-1:0]   opcode;
    logic [COORD_W-1:0]    row;
    logic [COORD_W-1:0]    col;
    logic                  cell_in;
    logic                  out_valid;
    logic                  out_ready;
    logic                  cell_out;

    cave_cellular_automaton uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .row       (row),
        .col       (col),
        .cell_in   (cell_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cell_out  (cell_out)
    );

    // grid predictor state
    bit                 cave [SIDE][SIDE];
    bit [LIMIT_W-1:0]   birth_lim;
    bit [LIMIT_W-1:0]   death_lim;
    bit [SIDE_W-1:0]    rows_reg;
    bit [SIDE_W-1:0]    cols_reg;
    bit                 expected_cells[$];

    int  errors;
    int  cycles;
    int  idle_pct;
    int  stall_pct;

    typedef struct {
        logic [OPCODE_W-1:0] op;
        logic [COORD_W-1:0]  r;
        logic [COORD_W-1:0]  c;
        logic                v;
        bit                  typed;
        bit                  exp;
    } stim_row_t;

    stim_row_t directed[] = '{
        '{OP_READ,   6'd0,  6'd0,  1'b1, 1'b1, 1'b0},
        '{OP_READ,   6'd63, 6'd63, 1'b0, 1'b1, 1'b0},
        '{OP_WRITE,  6'd0,  6'd0,  1'b1, 1'b0, 1'b0},
        '{OP_READ,   6'd0,  6'd0,  1'b0, 1'b1, 1'b1},
        '{OP_WRITE,  6'd63, 6'd63, 1'b1, 1'b0, 1'b0},
        '{OP_READ,   6'd63, 6'd63, 1'b0, 1'b1, 1'b1},
        '{OP_WRITE,  6'd0,  6'd63, 1'b1, 1'b0, 1'b0},
        '{OP_WRITE,  6'd63, 6'd0,  1'b1, 1'b0, 1'b0},
        '{OP_UNUSED, 6'd63, 6'd63, 1'b0, 1'b0, 1'b0},
        '{OP_READ,   6'd63, 6'd63, 1'b1, 1'b1, 1'b1},
        '{OP_WRITE,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
        '{OP_READ,   6'd0,  6'd0,  1'b0, 1'b1, 1'b0},
        '{OP_WRITE,  6'd31, 6'd32, 1'b1, 1'b0, 1'b0},
        '{OP_STEP,   6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
        '{OP_READ,   6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
        '{OP_READ,   6'd0,  6'd1,  1'b0, 1'b0, 1'b0},
        '{OP_READ,   6'd1,  6'd1,  1'b0, 1'b0, 1'b0},
        '{OP_READ,   6'd63, 6'd63, 1'b0, 1'b0, 1'b0},
        '{OP_READ,   6'd31, 6'd32, 1'b0, 1'b0, 1'b0},
        '{OP_STEP,   6'd0,  6'd0,  1'b1, 1'b0, 1'b0},
        '{OP_READ,   6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
        '{OP_READ,   6'd1,  6'd0,  1'b1, 1'b0, 1'b0}
    };

    function automatic int eff_side(bit [SIDE_W-1:0] v);
        if (v < 1) return 1;
        if (v > SIDE) return SIDE;
        return int'(v);
    endfunction

    function automatic bit region_live(int r, int c, int nr, int nc);
        if (r < 0 || c < 0 || r >= nr || c >= nc) return 1'b1;
        return cave[r][c];
    endfunction

    task automatic advance_generation();
        bit nxt [SIDE][SIDE];
        int nr;
        int nc;
        int cnt;
        nr  = eff_side(rows_reg);
        nc  = eff_side(cols_reg);
        nxt = cave;
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
            begin
                cnt = 0;
                for (int dr = -1; dr <= 1; dr++)
                    for (int dc = -1; dc <= 1; dc++)
                        if (dr != 0 || dc != 0)
                            cnt += int'(region_live(r + dr, c + dc, nr, nc));
                if (cave[r][c])
                    nxt[r][c] = (cnt < int'(death_lim)) ? 1'b0 : 1'b1;
                else
                    nxt[r][c] = (cnt > int'(birth_lim)) ? 1'b1 : 1'b0;
            end
        cave = nxt;
    endtask

    // apply one accepted beat; returns 1 and the cell when a read answers
    task automatic apply_beat(input logic [OPCODE_W-1:0] op, input int r, input int c,
                              input bit v, output bit answers, output bit val);
        bit hit;
        hit = (r < eff_side(rows_reg)) && (c < eff_side(cols_reg));
        answers = 1'b0;
        val     = 1'b0;
        case (op)
            OP_WRITE: if (hit) cave[r][c] = v;
            OP_STEP:  advance_generation();
            OP_READ:
            begin
                answers = 1'b1;
                val     = hit ? cave[r][c] : 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task automatic send_beat(input logic [OPCODE_W-1:0] op, input int r, input int c,
                             input bit v, input bit typed, input bit want);
        bit answers;
        bit val;
        in_valid <= 1'b1;
        opcode   <= op;
        row      <= r[COORD_W-1:0];
        col      <= c[COORD_W-1:0];
        cell_in  <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        apply_beat(op, r, c, v, answers, val);
        if (answers)
        begin
            if (typed && val != want) report_mismatch("table row", int'(val), int'(want));
            expected_cells.push_back(typed ? want : val);
        end
    endtask

    task automatic maybe_idle();
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_cells.size() != 0) @(posedge clk);
    endtask

    task automatic write_regs(input logic [CFG_DATA_W-1:0] b, input logic [CFG_DATA_W-1:0] d,
                              input logic [CFG_DATA_W-1:0] nr, input logic [CFG_DATA_W-1:0] nc);
        logic [CFG_DATA_W-1:0] vals [4];
        vals = '{b, d, nr, nc};
        drain();
        repeat (SETTLE) @(posedge clk);
        for (int i = 0; i < 4; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_wdata <= vals[i];
            @(posedge clk);
            case (i[CFG_IDX_W-1:0])
                REG_BIRTH_LIMIT: birth_lim = vals[i][LIMIT_W-1:0];
                REG_DEATH_LIMIT: death_lim = vals[i][LIMIT_W-1:0];
                REG_GRID_ROWS:   rows_reg  = vals[i][SIDE_W-1:0];
                REG_GRID_COLS:   cols_reg  = vals[i][SIDE_W-1:0];
                default: ;
            endcase
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: random stalls and checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_cells.size() == 0)
                report_mismatch("unexpected beat", int'(cell_out), 0);
            else if (cell_out !== expected_cells[0])
            begin
                report_mismatch("cell_out", int'(cell_out), int'(expected_cells[0]));
                void'(expected_cells.pop_front());
            end
            else
                void'(expected_cells.pop_front());
        end
        out_ready <= (stall_pct > 0 && $urandom_range(99) < stall_pct) ? 1'b0 : 1'b1;
    end

    initial
    begin
        int nr;
        int nc;
        int op_pick;
        int r;
        int c;
        logic [OPCODE_W-1:0] op;
        logic [CFG_DATA_W-1:0] phase_cfg [6][4];

        phase_cfg = '{
            '{7'd4,  7'd3,  7'd64,  7'd64},
            '{7'd0,  7'd0,  7'd1,   7'd1},
            '{7'h7F, 7'h7F, 7'd0,   7'd127},
            '{7'd2,  7'd5,  7'd8,   7'd8},
            '{7'h0B, 7'h74, 7'd100, 7'd3},
            '{7'd3,  7'd4,  7'd12,  7'd20}
        };

        errors    = 0;
        idle_pct  = 0;
        stall_pct = 0;
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        opcode    = '0;
        row       = '0;
        col       = '0;
        cell_in   = 1'b0;
        foreach (cave[i, j]) cave[i][j] = 1'b0;
        birth_lim = BIRTH_LIMIT_RST;
        death_lim = DEATH_LIMIT_RST;
        rows_reg  = GRID_SIDE_RST;
        cols_reg  = GRID_SIDE_RST;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            send_beat(directed[i].op, int'(directed[i].r), int'(directed[i].c),
                      directed[i].v, directed[i].typed, directed[i].exp);

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph < 5)
                write_regs(phase_cfg[ph][0], phase_cfg[ph][1],
                           phase_cfg[ph][2], phase_cfg[ph][3]);
            else
                write_regs(CFG_DATA_W'($urandom_range(127)), CFG_DATA_W'($urandom_range(127)),
                           CFG_DATA_W'($urandom_range(1, 16)),
                           CFG_DATA_W'($urandom_range(1, 16)));
            nr = eff_side(rows_reg);
            nc = eff_side(cols_reg);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ((i / 50) % 3 == 2)
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                else
                begin
                    idle_pct  = (ph % 4 == 1) ? 53 : (ph % 4 == 3) ? 30 : 0;
                    stall_pct = (ph % 4 == 2) ? 53 : (ph % 4 == 3) ? 30 : 0;
                end
                if (i == 100) drain();
                op_pick = $urandom_range(99);
                op = (op_pick < 45) ? OP_WRITE :
                     (op_pick < 85) ? OP_READ  :
                     (op_pick < 97) ? OP_STEP  : OP_UNUSED;
                if ($urandom_range(99) < 20)
                begin
                    r = $urandom_range(SIDE - 1);
                    c = $urandom_range(SIDE - 1);
                end
                else
                begin
                    r = $urandom_range(nr - 1);
                    c = $urandom_range(nc - 1);
                end
                maybe_idle();
                send_beat(op, r, c, 1'($urandom_range(1)), 1'b0, 1'b0);
            end
        end

        drain();
        idle_pct  = 0;
        stall_pct = 0;
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

/* cave_cellular_automaton.f */
rtl/cave_pkg.sv
rtl/cave_cellular_automaton.sv
tb/tb_cave_cellular_automaton.sv
